### hdl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// shared types, phase encoding, error codes and byte constants for the
// chunked body decoder
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;
    localparam int COUNT_W    = 32;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_UX = 8'h58;

    localparam logic [4:0] HEX_NONE = 5'd16;

    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_LINE,
        PH_DATA,
        PH_WANT_CR,
        PH_WANT_LF,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NOT_HEX,
        ERR_PREFIX,
        ERR_OVERFLOW,
        ERR_CRLF
    } t_err;

    typedef struct packed {
        logic               payload_valid;
        logic [7:0]         payload_byte;
        logic               body_done;
        logic [2:0]         error_code;
        logic [COUNT_W-1:0] total_payload;
    } t_result;

    // digit value 0..15, or HEX_NONE when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = HEX_NONE;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 5'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 5'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 5'(b - 8'h37);
        end
        return v;
    endfunction

endpackage

### hdl/chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// chunked_body_decoder
// decodes a chunked http message body one byte per word, passing chunk data
// through with end, error and running count on every result word
//
// channel   dir  tdata                                   tuser
// s_axis    in   [7:0] data_byte                         [0] cmd
// m_axis    out  [7:0] payload_byte, [8] body_done,      [0] payload_valid
//                [11:9] error_code, [43:12] total_payload
//
// one word per cycle sustained while m_axis_tready holds, one result word per input word
// an accepted input word goes into the input register, then the decode step
// writes its result word into the result register
// reset is synchronous and active low and clears the decoder state
// a stalled result word holds, the input register takes one more word and
// then the input stalls until the result word is taken
// ----------------------------------------------------------------------------
module chunked_body_decoder
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tuser,   // [0] cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // payload_byte, body_done, error_code, total_payload
    output logic                  m_axis_tuser    // [0] payload_valid
);

    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_res;
    t_result    core_res;
    logic       step;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    cbd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cmd   (r_in_cmd),
        .i_byte  (r_in_byte),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_res.payload_valid;
    assign m_axis_tdata  = {4'd0, r_res.total_payload, r_res.error_code,
                            r_res.body_done, r_res.payload_byte};

endmodule

### hdl/cbd_core.sv
// ----------------------------------------------------------------------------
// cbd_core
// decoder state and the one-word step: size line parsing, data pass-through,
// crlf checks, held end and error, saturating payload count
// ----------------------------------------------------------------------------
module cbd_core
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_cmd,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_size_accum, n_size_accum;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic                 r_prev_cr, n_prev_cr;
    logic                 r_digits_open, n_digits_open;
    logic [1:0]           r_line_index, n_line_index;
    logic [COUNT_W-1:0]   r_payload_count, n_payload_count;
    t_err                 r_held_error, n_held_error;

    logic [4:0] hex_v;
    logic       is_hex;
    logic       pass_valid;

    assign hex_v  = hex_value(i_byte);
    assign is_hex = (hex_v != HEX_NONE);

    always_comb begin
        n_phase         = r_phase;
        n_size_accum    = r_size_accum;
        n_bytes_left    = r_bytes_left;
        n_prev_cr       = r_prev_cr;
        n_digits_open   = r_digits_open;
        n_line_index    = r_line_index;
        n_payload_count = r_payload_count;
        n_held_error    = r_held_error;
        pass_valid      = 1'b0;

        if (i_cmd) begin
            n_phase         = PH_LINE_START;
            n_size_accum    = '0;
            n_bytes_left    = '0;
            n_prev_cr       = 1'b0;
            n_digits_open   = 1'b1;
            n_line_index    = '0;
            n_payload_count = '0;
            n_held_error    = ERR_NONE;
        end else begin
            case (r_phase)
                PH_LINE_START, PH_LINE: begin
                    if (r_line_index == 2'd0 && !is_hex) begin
                        n_held_error = ERR_NOT_HEX;
                        n_phase      = PH_ERROR;
                    end else if (r_line_index == 2'd1 && r_size_accum == '0 &&
                                 r_digits_open && (i_byte == CH_LX || i_byte == CH_UX)) begin
                        n_held_error = ERR_PREFIX;
                        n_phase      = PH_ERROR;
                    end else if (r_digits_open && is_hex &&
                                 r_size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                        n_held_error = ERR_OVERFLOW;
                        n_phase      = PH_ERROR;
                    end else begin
                        if (r_digits_open) begin
                            if (is_hex) begin
                                n_size_accum = {r_size_accum[SIZE_BITS-5:0], hex_v[3:0]};
                            end else begin
                                n_digits_open = 1'b0;
                            end
                        end
                        if (r_line_index != 2'd2) begin
                            n_line_index = r_line_index + 2'd1;
                        end
                        n_phase = PH_LINE;
                        if (i_byte == CH_LF && r_prev_cr) begin
                            if (n_size_accum == '0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_bytes_left = n_size_accum;
                                n_phase      = PH_DATA;
                            end
                        end else begin
                            n_prev_cr = (i_byte == CH_CR);
                        end
                    end
                end
                PH_DATA: begin
                    pass_valid = 1'b1;
                    if (r_payload_count != '1) begin
                        n_payload_count = r_payload_count + COUNT_W'(1);
                    end
                    if (r_bytes_left != '0) begin
                        n_bytes_left = r_bytes_left - SIZE_BITS'(1);
                    end
                    if (n_bytes_left == '0) begin
                        n_phase = PH_WANT_CR;
                    end
                end
                PH_WANT_CR: begin
                    if (i_byte == CH_CR) begin
                        n_phase = PH_WANT_LF;
                    end else begin
                        n_held_error = ERR_CRLF;
                        n_phase      = PH_ERROR;
                    end
                end
                PH_WANT_LF: begin
                    if (i_byte == CH_LF) begin
                        n_phase       = PH_LINE_START;
                        n_size_accum  = '0;
                        n_prev_cr     = 1'b0;
                        n_digits_open = 1'b1;
                        n_line_index  = '0;
                    end else begin
                        n_held_error = ERR_CRLF;
                        n_phase      = PH_ERROR;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_res.payload_valid = pass_valid;
        o_res.payload_byte  = pass_valid ? i_byte : 8'd0;
        o_res.body_done     = (n_phase == PH_DONE);
        o_res.error_code    = n_held_error;
        o_res.total_payload = n_payload_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_LINE_START;
            r_size_accum    <= '0;
            r_bytes_left    <= '0;
            r_prev_cr       <= 1'b0;
            r_digits_open   <= 1'b1;
            r_line_index    <= '0;
            r_payload_count <= '0;
            r_held_error    <= ERR_NONE;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_size_accum    <= n_size_accum;
            r_bytes_left    <= n_bytes_left;
            r_prev_cr       <= n_prev_cr;
            r_digits_open   <= n_digits_open;
            r_line_index    <= n_line_index;
            r_payload_count <= n_payload_count;
            r_held_error    <= n_held_error;
        end
    end

endmodule

### hdl/cbd_checker.sv
// ----------------------------------------------------------------------------
// cbd_checker
// port-level checks on the decoder result stream
// ----------------------------------------------------------------------------
module cbd_checker
    import cbd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // data only passes while the body is open and clean
    a_pass_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            !m_axis_tdata[8] && m_axis_tdata[11:9] == 3'(ERR_NONE))
        else $error("payload passed after end or error");

    // end and error exclude each other
    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[11:9] == 3'(ERR_NONE))
        else $error("body end reported together with an error");

    // error code is one of the defined codes
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[11:9] == 3'(ERR_NONE) || m_axis_tdata[11:9] == 3'(ERR_NOT_HEX) ||
            m_axis_tdata[11:9] == 3'(ERR_PREFIX) || m_axis_tdata[11:9] == 3'(ERR_OVERFLOW) ||
            m_axis_tdata[11:9] == 3'(ERR_CRLF))
        else $error("undefined error code");

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
